[sv/fct_pkg.sv]
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull test block.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned PlaneAw   = (NumPlanes > 1) ? $clog2(NumPlanes) : 1;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_POINT  = 2'd1,
    FUNC_SPHERE = 2'd2,
    FUNC_BOX    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  // one stored plane: point and normal, Q16.16
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } plane_t;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic        [30:0] radius;
  } item_t;

  // pipeline tag traveling with each plane evaluation
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

endpackage

[sv/frustum_cull_test.sv]
// ----------------------------------------------------------------------------
// frustum_cull_test
// Six-plane view frustum culling: plane store plus point, sphere and box test.
//
// An item is taken at a rising edge with start high and busy low. A load item
// (func load plane) writes one plane slot and gives no result;
// slots beyond the plane count are ignored. A test item reads the planes from
// the plane memory one per cycle and streams them through the shared
// three-term distance pipeline (memory read, difference, products, sum).
// Its result appears on inside_res_o with strobe_o high for exactly one cycle,
// after the last plane is issued and has passed the difference, products,
// sum and result registers;
// busy stays high until the cycle of the strobe, in which the next item may
// already be taken. A load item is followed by busy low in the next cycle.
// The receiver cannot stall: each strobe cycle is one transaction.
// Reset makes every plane read as zero (all tests pass) and leaves the block
// idle with no result pending.
// ----------------------------------------------------------------------------
module frustum_cull_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [2:0]  plane_index_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_i,
  input  logic [31:0] bz_i,
  input  logic [30:0] radius_i,
  output logic        strobe_o,
  output logic        inside_res_o
);

  localparam logic [fct_pkg::PlaneAw-1:0] LastPlane =
    fct_pkg::PlaneAw'(fct_pkg::NumPlanes - 1);

  fct_pkg::state_e                state_q, state_d;
  logic [fct_pkg::PlaneAw-1:0]    cnt_q, cnt_d;
  fct_pkg::item_t                 item_q;
  logic                           accept;
  fct_pkg::func_e                 func_in;
  logic                           load_we;
  fct_pkg::plane_t                wdata;
  fct_pkg::tag_t                  rd_tag;
  fct_pkg::plane_t                mem_rdata;
  fct_pkg::tag_t                  mem_tag;
  logic                           cull;
  fct_pkg::tag_t                  dot_tag;
  logic                           inside_q, inside_d;
  logic                           strobe_q, strobe_d;
  logic                           res_q, res_d;

  assign func_in = fct_pkg::func_e'(func_i);
  assign accept  = start && !busy;
  assign load_we = accept && (func_in == fct_pkg::FUNC_LOAD) &&
                   (32'(plane_index_i) < fct_pkg::NumPlanes);
  assign wdata   = '{px: ax_i, py: ay_i, pz: az_i, nx: bx_i, ny: by_i, nz: bz_i};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{func: func_in, ax: ax_i, ay: ay_i, az: az_i,
                  bx: bx_i, by: by_i, bz: bz_i, radius: radius_i};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      fct_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept && func_in != fct_pkg::FUNC_LOAD) begin
          state_d = fct_pkg::ST_ISSUE;
        end
      end
      fct_pkg::ST_ISSUE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastPlane) begin
          state_d = fct_pkg::ST_DRAIN;
        end
      end
      fct_pkg::ST_DRAIN: begin
        if (dot_tag.vld && dot_tag.last) begin
          state_d = fct_pkg::ST_IDLE;
        end
      end
      default: state_d = fct_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_tag = '0;
    busy   = 1'b1;
    unique case (state_q)
      fct_pkg::ST_IDLE:  busy = 1'b0;
      fct_pkg::ST_ISSUE: begin
        rd_tag.vld  = 1'b1;
        rd_tag.last = (cnt_q == LastPlane);
      end
      fct_pkg::ST_DRAIN: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // verdict accumulation over the planes
  always_comb begin
    inside_d = inside_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    if (accept) begin
      inside_d = 1'b1;
    end else if (dot_tag.vld) begin
      inside_d = inside_q && !cull;
      if (dot_tag.last) begin
        strobe_d = 1'b1;
        res_d    = inside_q && !cull;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fct_pkg::ST_IDLE;
      cnt_q    <= '0;
      inside_q <= 1'b1;
      strobe_q <= 1'b0;
      res_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      inside_q <= inside_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
    end
  end

  fct_plane_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_we),
    .waddr_i (fct_pkg::PlaneAw'(plane_index_i)),
    .wdata_i (wdata),
    .raddr_i (cnt_q),
    .rtag_i  (rd_tag),
    .rdata_o (mem_rdata),
    .rtag_o  (mem_tag)
  );

  fct_dot_unit u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .plane_i (mem_rdata),
    .tag_i   (mem_tag),
    .cull_o  (cull),
    .tag_o   (dot_tag)
  );

  assign strobe_o     = strobe_q;
  assign inside_res_o = res_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("back-to-back result strobes");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i != fct_pkg::FUNC_LOAD) |=> busy)
    else $error("test transaction did not raise busy");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == fct_pkg::FUNC_LOAD) |=> (!busy && !strobe_o))
    else $error("load transaction caused busy or a result");

endmodule

[sv/fct_plane_mem.sv]
// ----------------------------------------------------------------------------
// fct_plane_mem
// Plane store: one-write, one-read synchronous memory with registered read
// data. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fct_plane_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [fct_pkg::PlaneAw-1:0]   waddr_i,
  input  fct_pkg::plane_t               wdata_i,
  input  logic [fct_pkg::PlaneAw-1:0]   raddr_i,
  input  fct_pkg::tag_t                 rtag_i,
  output fct_pkg::plane_t               rdata_o,
  output fct_pkg::tag_t                 rtag_o
);

  fct_pkg::plane_t                 mem [fct_pkg::NumPlanes];
  logic [fct_pkg::NumPlanes-1:0]   vld_q;
  fct_pkg::plane_t                 rdata_q;
  fct_pkg::tag_t                   rtag_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rtag_i.vld) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rtag_q <= '0;
    end else begin
      rtag_q <= rtag_i;
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign rtag_o  = rtag_q;

endmodule

[sv/fct_dot_unit.sv]
// ----------------------------------------------------------------------------
// fct_dot_unit
// Three-stage signed distance unit: vertex select and difference, three exact
// products, exact sum with sphere bias and sign test. One plane per cycle.
// ----------------------------------------------------------------------------
module fct_dot_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fct_pkg::item_t   item_i,
  input  fct_pkg::plane_t  plane_i,
  input  fct_pkg::tag_t    tag_i,
  output logic             cull_o,
  output fct_pkg::tag_t    tag_o
);

  logic               is_box;
  logic signed [31:0] vx, vy, vz;
  logic signed [32:0] dx_d, dy_d, dz_d;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [31:0] nx_q, ny_q, nz_q;
  logic signed [64:0] prx_q, pry_q, prz_q;
  logic        [46:0] bias;
  logic signed [66:0] sum;
  logic               cull_q;
  fct_pkg::tag_t      tag_a_q, tag_b_q, tag_c_q;

  // stage A: positive vertex for box tests, then v - p
  always_comb begin
    is_box = (item_i.func == fct_pkg::FUNC_BOX);
    vx = (is_box && !plane_i.nx[31]) ? item_i.bx : item_i.ax;
    vy = (is_box && !plane_i.ny[31]) ? item_i.by : item_i.ay;
    vz = (is_box && !plane_i.nz[31]) ? item_i.bz : item_i.az;
    dx_d = {vx[31], vx} - {plane_i.px[31], plane_i.px};
    dy_d = {vy[31], vy} - {plane_i.py[31], plane_i.py};
    dz_d = {vz[31], vz} - {plane_i.pz[31], plane_i.pz};
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
    nx_q  <= plane_i.nx;
    ny_q  <= plane_i.ny;
    nz_q  <= plane_i.nz;
    prx_q <= dx_q * nx_q;
    pry_q <= dy_q * ny_q;
    prz_q <= dz_q * nz_q;
    cull_q <= sum[66];
  end

  // stage C: Q32.32 sum, radius moved to Q32.32 for sphere tests
  always_comb begin
    bias = (item_i.func == fct_pkg::FUNC_SPHERE) ? {item_i.radius, 16'b0} : '0;
    sum  = 67'(prx_q) + 67'(pry_q) + 67'(prz_q) + $signed({20'b0, bias});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  assign cull_o = cull_q;
  assign tag_o  = tag_c_q;

endmodule
